[sv/byte_escape_dump_encoder_top_assert.svh]
// assertion macros for the byte escape dump encoder checker
// used by bede_checker, expects clk and rst_n in scope
`ifndef BYTE_ESCAPE_DUMP_ENCODER_TOP_ASSERT_SVH
`define BYTE_ESCAPE_DUMP_ENCODER_TOP_ASSERT_SVH

// clocked check, off while in reset
`define BEDE_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also covers reset cycles
`define BEDE_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/bede_pkg.sv]
// shared types, character codes and sizes for the byte escape dump encoder
// no dependencies
`default_nettype none

package bede_pkg;

  localparam int MAX_CHARS       = 5;
  localparam int CHAR_W          = 7;
  localparam int COUNT_W         = 3;
  localparam int COL_W           = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [COL_W-1:0] LIMIT_RESET = 8'd60;

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CHAR_W-1:0] CH_LF     = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 7'h5C;
  localparam logic [CHAR_W-1:0] CH_TILDE  = 7'h7E;
  localparam logic [CHAR_W-1:0] CH_CARET  = 7'h5E;
  localparam logic [CHAR_W-1:0] CH_QMARK  = 7'h3F;
  localparam logic [CHAR_W-1:0] CH_DEL    = 7'h7F;
  localparam logic [CHAR_W-1:0] CTRL_MASK = 7'h1F;
  localparam logic [CHAR_W-1:0] CTRL_OR   = 7'h40;
  localparam logic [7:0]        BYTE_LF   = 8'h0A;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              end_of_run;
  } out_item_t;

  typedef struct packed {
    logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
    logic [COUNT_W-1:0]               count;
  } run_t;

endpackage

`default_nettype wire

[sv/bede_front.sv]
// front end: line limit register, column counter and byte classification
// builds one run of up to five characters per beat; depends on bede_pkg
`default_nettype none

module bede_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bede_pkg::in_item_t in_item,
  input  wire logic               q_full,
  output logic                    accept,
  output logic                    q_wr,
  output bede_pkg::run_t          q_run,
  input  wire logic               cfg_valid,
  input  wire logic [7:0]         cfg_data
);
  import bede_pkg::*;

  logic [COL_W-1:0]   limit_r, limit_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [CHAR_W-1:0]  c, e0, e1;
  logic               hi, nl7, brk, two;
  logic [COUNT_W-1:0] n, len;
  logic [COL_W-1:0]   base;
  logic [COL_W:0]     sum;
  run_t               run;

  assign accept = push && !q_full;
  assign q_wr   = accept && (run.count != '0);
  assign q_run  = run;

  always_comb begin
    c   = in_item.data_byte[6:0];
    hi  = in_item.data_byte[7];
    nl7 = (c == CH_LF);
    e0  = c;
    e1  = c;
    two = 1'b0;
    if (hi && nl7) begin
      e0  = CH_CARET;
      e1  = c | CTRL_OR;
      two = 1'b1;
    end else if (hi && c == CH_TILDE) begin
      e0 = CH_TILDE;
    end else if (nl7) begin
      e0 = CH_LF;
    end else if (c == CH_TILDE || c == CH_CARET || c == CH_BSLASH) begin
      e0  = CH_BSLASH;
      e1  = c;
      two = 1'b1;
    end else if (c == CH_DEL) begin
      e0  = CH_CARET;
      e1  = CH_QMARK;
      two = 1'b1;
    end else if ((c & ~CTRL_MASK) != '0) begin
      e0 = c;
    end else begin
      e0  = CH_CARET;
      e1  = c | CTRL_OR;
      two = 1'b1;
    end

    if (!hi && nl7) begin
      len = '0;
    end else begin
      len = COUNT_W'(hi) + (two ? COUNT_W'(2) : COUNT_W'(1));
    end

    if (in_item.opcode == OP_FLUSH) begin
      brk = (col_r != '0);
    end else begin
      brk = (col_r >= limit_r) && (in_item.data_byte != BYTE_LF);
    end

    run.chars = '0;
    n = '0;
    if (brk) begin
      run.chars[0] = CH_BSLASH;
      run.chars[1] = CH_LF;
      n = COUNT_W'(2);
    end
    if (in_item.opcode == OP_DATA) begin
      if (hi) begin
        run.chars[n] = CH_TILDE;
        n = n + 1'b1;
      end
      run.chars[n] = e0;
      n = n + 1'b1;
      if (two) begin
        run.chars[n] = e1;
        n = n + 1'b1;
      end
    end
    run.count = n;

    base = brk ? '0 : col_r;
    sum  = {1'b0, base} + (COL_W+1)'(len);
    if (in_item.opcode == OP_FLUSH || in_item.data_byte == BYTE_LF) begin
      col_nxt = '0;
    end else if (sum[COL_W]) begin
      col_nxt = '1;
    end else begin
      col_nxt = sum[COL_W-1:0];
    end

    limit_nxt = cfg_valid ? cfg_data : limit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      col_r   <= '0;
    end else begin
      limit_r <= limit_nxt;
      if (accept) begin
        col_r <= col_nxt;
      end
    end
  end

endmodule

`default_nettype wire

[sv/bede_queue.sv]
// short run queue between front and back end
// register array with read and write pointers; depends on bede_pkg
`default_nettype none

module bede_queue #(
  parameter int DEPTH = bede_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr,
  input  wire bede_pkg::run_t wr_run,
  output logic                full,
  input  wire logic           rd,
  output logic                nonempty,
  output bede_pkg::run_t      rd_run
);
  import bede_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  run_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign rd_run   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr && !rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (rd && !wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_run;
    end
  end

endmodule

`default_nettype wire

[sv/bede_back.sv]
// back end: walks the head run one character per beat into the output register
// while it is free or being popped; depends on bede_pkg
`default_nettype none

module bede_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_nonempty,
  input  wire bede_pkg::run_t q_run,
  output logic                q_rd,
  output logic                empty,
  input  wire logic           pop,
  output bede_pkg::out_item_t out_item
);
  import bede_pkg::*;

  logic [COUNT_W-1:0] idx_r, idx_nxt;
  logic               vld_r, vld_nxt;
  out_item_t          out_r, out_nxt;
  logic               load, last;

  assign empty    = !vld_r;
  assign out_item = out_r;

  always_comb begin
    load    = q_nonempty && (!vld_r || pop);
    last    = (idx_r == q_run.count - 1'b1);
    q_rd    = load && last;
    idx_nxt = idx_r;
    vld_nxt = vld_r;
    out_nxt = out_r;
    if (load) begin
      out_nxt.out_char   = q_run.chars[idx_r];
      out_nxt.end_of_run = last;
      vld_nxt            = 1'b1;
      idx_nxt            = last ? '0 : idx_r + 1'b1;
    end else if (pop) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      vld_r <= 1'b0;
    end else begin
      idx_r <= idx_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

`default_nettype wire

[sv/byte_escape_dump_encoder_top.sv]
// byte escape dump encoder: input byte stream to printable ascii with soft wrap
// top level; instantiates bede_front, bede_queue and bede_back, uses bede_pkg
//
// input side is a queue: a beat (opcode, data_byte) is taken when push is high
// and full is low. output side is a queue too: while empty is low the oldest
// character sits on out_item and leaves on a cycle with pop high.
// cfg_data is the line limit, written on cfg_valid; cfg_ready is always high.
// each data byte gives 1 to 5 characters, a flush 0 or 2; end_of_run marks the
// last character of one input beat.
// the first character of a beat passes through the run queue and then the
// output register before it shows on out_item. the output register delivers
// one character per cycle while pop is high; the front takes a beat every
// cycle while the run queue has room.
// when pop is held low the output register holds, the run queue fills and
// full rises. reset clears column and both queues and sets the line limit to 60.
`default_nettype none

module byte_escape_dump_encoder_top #(
  parameter int QUEUE_DEPTH = bede_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire bede_pkg::in_item_t in_item,
  output logic                    empty,
  input  wire logic               pop,
  output bede_pkg::out_item_t     out_item,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [7:0]         cfg_data
);
  import bede_pkg::*;

  logic accept, q_wr, q_full, q_rd, q_nonempty;
  run_t wr_run, rd_run;

  assign cfg_ready = 1'b1;
  assign full      = q_full;

  bede_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .in_item   (in_item),
    .q_full    (q_full),
    .accept    (accept),
    .q_wr      (q_wr),
    .q_run     (wr_run),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data)
  );

  bede_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (q_wr && accept),
    .wr_run   (wr_run),
    .full     (q_full),
    .rd       (q_rd),
    .nonempty (q_nonempty),
    .rd_run   (rd_run)
  );

  bede_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_run      (rd_run),
    .q_rd       (q_rd),
    .empty      (empty),
    .pop        (pop),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire

[sv/bede_checker.sv]
// port level checks for byte_escape_dump_encoder_top, bound to the top level
// uses bede_pkg and byte_escape_dump_encoder_top_assert.svh
`default_nettype none

`include "byte_escape_dump_encoder_top_assert.svh"

module bede_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                push,
  input wire logic                full,
  input wire bede_pkg::in_item_t  in_item,
  input wire logic                empty,
  input wire logic                pop,
  input wire bede_pkg::out_item_t out_item,
  input wire logic                cfg_valid,
  input wire logic                cfg_ready,
  input wire logic [7:0]          cfg_data
);
  import bede_pkg::*;

  `BEDE_ASSERT_ANY(a_rst_empty, !rst_n |=> empty, "output not empty after reset")
  `BEDE_ASSERT_ANY(a_rst_not_full, !rst_n |=> !full, "input full after reset")
  `BEDE_ASSERT_RUN(a_hold, !empty && !pop |=> !empty && $stable(out_item), "stalled beat changed")
  `BEDE_ASSERT_RUN(a_data_out, push && !full && in_item.opcode == OP_DATA |-> ##2 !empty, "data beat gave no output")

endmodule

bind byte_escape_dump_encoder_top bede_checker u_bede_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .push      (push),
  .full      (full),
  .in_item   (in_item),
  .empty     (empty),
  .pop       (pop),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_data  (cfg_data)
);

`default_nettype wire

[verif/bede_escape_checker.sv]
`timescale 1ns / 100ps
// bede_escape_checker: watches the input, result and line limit channels of the
// byte escape dump encoder, predicts every output character and compares them
// depends on bede_pkg for the beat types and character codes
module bede_escape_checker
  import bede_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  logic       full,
  input  in_item_t   in_item,
  input  logic       empty,
  input  logic       pop,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output int         mismatch_count,
  output int         chars_pending
);

  localparam logic [COL_W-1:0] COL_MAX = 8'hFF;

  logic [COL_W-1:0] line_limit;
  logic [COL_W-1:0] column;
  out_item_t        expected_chars[$];
  int               chars_seen;

  initial mismatch_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: char %0d %s got 0x%0h want 0x%0h", chars_seen, what, got, want);
    mismatch_count++;
  endtask

  // appends the characters one input beat produces and updates the column
  task automatic encode_beat(input in_item_t beat);
    logic [CHAR_W-1:0] run[$];
    logic [CHAR_W-1:0] low7;
    int unsigned       width_add;
    int unsigned       sum;
    out_item_t         rec;
    low7      = beat.data_byte[6:0];
    width_add = 0;
    if (beat.opcode == OP_FLUSH) begin
      if (column != 0) begin
        run.push_back(CH_BSLASH);
        run.push_back(CH_LF);
      end
      column = '0;
    end else begin
      if (column >= line_limit && beat.data_byte != BYTE_LF) begin
        run.push_back(CH_BSLASH);
        run.push_back(CH_LF);
        column = '0;
      end
      if (beat.data_byte[7]) begin
        run.push_back(CH_TILDE);
        width_add = 1;
      end
      if (beat.data_byte[7] && low7 == CH_LF) begin
        run.push_back(CH_CARET);
        run.push_back(low7 | CTRL_OR);
        width_add = 3;
      end else if (beat.data_byte[7] && low7 == CH_TILDE) begin
        run.push_back(CH_TILDE);
        width_add = 2;
      end else if (low7 == CH_LF) begin
        run.push_back(CH_LF);
      end else if (low7 == CH_TILDE || low7 == CH_CARET || low7 == CH_BSLASH) begin
        run.push_back(CH_BSLASH);
        run.push_back(low7);
        width_add += 2;
      end else if (low7 == CH_DEL) begin
        run.push_back(CH_CARET);
        run.push_back(CH_QMARK);
        width_add += 2;
      end else if ((low7 & ~CTRL_MASK) != 0) begin
        run.push_back(low7);
        width_add += 1;
      end else begin
        run.push_back(CH_CARET);
        run.push_back(low7 | CTRL_OR);
        width_add += 2;
      end
      sum    = column + width_add;
      column = (sum > COL_MAX) ? COL_MAX : sum[COL_W-1:0];
      if (beat.data_byte == BYTE_LF) column = '0;
    end
    foreach (run[i]) begin
      rec.out_char   = run[i];
      rec.end_of_run = (i == run.size() - 1);
      expected_chars.push_back(rec);
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      line_limit = LIMIT_RESET;
      column     = '0;
      chars_seen = 0;
      expected_chars.delete();
    end else begin
      if (cfg_valid && cfg_ready) line_limit = cfg_data;
      if (pop && !empty) begin
        if (expected_chars.size() == 0) begin
          report_mismatch("unexpected beat, out_char", out_item.out_char, 0);
        end else begin
          want = expected_chars.pop_front();
          if (out_item.out_char !== want.out_char)
            report_mismatch("out_char", out_item.out_char, want.out_char);
          if (out_item.end_of_run !== want.end_of_run)
            report_mismatch("end_of_run", out_item.end_of_run, want.end_of_run);
        end
        chars_seen++;
      end
      if (push && !full) encode_beat(in_item);
    end
    chars_pending <= expected_chars.size();
  end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: stimulus and verdict for byte_escape_dump_encoder_top
// depends on bede_pkg, the encoder rtl and bede_escape_checker
module tb_top;
  import bede_pkg::*;

  localparam int PHASE_BEATS  = 75;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int N_DIRECTED   = 18;
  localparam int N_SPECIAL    = 12;

  localparam logic [7:0] DIRECTED_BYTES [0:N_DIRECTED-1] = '{
    8'h00, 8'h1F, 8'h20, 8'h41, 8'h7E, 8'h5E, 8'h5C, 8'h7F, 8'h0A,
    8'h80, 8'h8A, 8'hFE, 8'hDE, 8'hDC, 8'hFF, 8'h9F, 8'hC1, 8'hA0
  };
  localparam logic [7:0] SPECIAL_BYTES [0:N_SPECIAL-1] = '{
    8'h0A, 8'h8A, 8'hFE, 8'h7E, 8'h5E, 8'h5C, 8'h7F, 8'hFF, 8'hDE, 8'hDC, 8'h00, 8'h80
  };

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_item;
  logic       empty;
  logic       pop;
  out_item_t  out_item;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  int mismatch_count;
  int chars_pending;
  int cycle_count;
  int tx_max_gap;
  int rx_max_gap;
  bit hold_req;

  byte_escape_dump_encoder_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_item   (in_item),
    .empty     (empty),
    .pop       (pop),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  bede_escape_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_item        (in_item),
    .empty          (empty),
    .pop            (pop),
    .out_item       (out_item),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n     = 1'b0;
    push      = 1'b0;
    in_item   = '0;
    pop       = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    hold_req  = 1'b0;
    tx_max_gap = 19;
    rx_max_gap = 19;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // offers one beat after a random gap, returns in the step it is taken
  task automatic send_beat(input in_item_t beat);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push    <= 1'b1;
    in_item <= beat;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(input logic [7:0] value);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t random_beat();
    in_item_t    beat;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    beat.opcode    = OP_DATA;
    beat.data_byte = 8'($urandom_range(0, 255));
    if (pick < 6) beat.opcode = OP_FLUSH;
    else if (pick < 14) beat.data_byte = BYTE_LF;
    else if (pick < 36) beat.data_byte = SPECIAL_BYTES[$urandom_range(0, N_SPECIAL - 1)];
    return beat;
  endfunction

  function automatic in_item_t data_beat(input logic [7:0] value);
    in_item_t beat;
    beat.opcode    = OP_DATA;
    beat.data_byte = value;
    return beat;
  endfunction

  // result side: random pops, with a long hold-off on request
  initial begin
    int gap;
    int beats;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    beats = 0;
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if (beats % 16 == 0) rx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
      gap = $urandom_range(0, rx_max_gap);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      beats++;
    end
  end

  initial begin
    logic [7:0] limits [0:5];
    in_item_t   flush_beat;
    flush_beat.opcode    = OP_FLUSH;
    flush_beat.data_byte = 8'hFF;
    limits = '{8'd1, 8'd250, 8'd7, 8'd33, 8'd2, 8'($urandom_range(1, 250))};
    @(posedge clk);
    while (!rst_n) @(posedge clk);

    // directed part at the reset line limit
    foreach (DIRECTED_BYTES[i]) send_beat(data_beat(DIRECTED_BYTES[i]));
    send_beat(flush_beat);
    send_beat(flush_beat);
    send_beat(data_beat(BYTE_LF));
    send_beat(data_beat(8'h8A));

    foreach (limits[p]) begin
      write_limit(limits[p]);
      for (int k = 0; k < PHASE_BEATS; k++) begin
        if (k % 20 == 0) tx_max_gap = ($urandom_range(0, 3) == 0) ? 0 : 19;
        if (p == 1 && k == 20) hold_req = 1'b1;
        if (p == 1 && k >= 20 && k < 45) tx_max_gap = 0;
        if (p == 3 && k == 40) wait_drained();
        send_beat(random_beat());
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
